[design/pal_pkg.sv]
// ----------------------------------------------------------------------------
// pal_pkg
// Shared types and codes for the positional array list: item kinds, result
// status codes and the command broadcast along the row of storage cells.
// ----------------------------------------------------------------------------
package pal_pkg;

  localparam int WORD_W = 32;
  localparam int POS_W  = 7;
  localparam int CAP_W  = 7;
  localparam int STAT_W = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [1:0] {
    KIND_INS = 2'd0,
    KIND_DEL = 2'd1,
    KIND_RD  = 2'd2,
    KIND_NOP = 2'd3
  } pal_kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } pal_status_t;

  // Broadcast to every cell: which shift to apply and the word to insert.
  typedef struct packed {
    logic              ins;
    logic              del;
    logic [WORD_W-1:0] word;
  } pal_cmd_t;

endpackage

[design/pal_cell.sv]
// ----------------------------------------------------------------------------
// pal_cell
// One list entry. On insert it takes its left neighbor's word when it sits
// above the position, or the new word at the position; on delete it takes
// its right neighbor's word from the position upward.
// ----------------------------------------------------------------------------
module pal_cell
  import pal_pkg::*;
#(
  parameter int IW = 7
) (
  input  logic              clk,
  input  pal_cmd_t          cmd,
  input  logic [IW-1:0]     pos,
  input  logic [IW-1:0]     idx,
  input  logic [WORD_W-1:0] left_data,
  input  logic [WORD_W-1:0] right_data,
  output logic [WORD_W-1:0] data
);

  logic [WORD_W-1:0] data_r;
  logic [WORD_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (cmd.ins) begin
      if (idx > pos) begin
        data_nxt = left_data;
      end else if (idx == pos) begin
        data_nxt = cmd.word;
      end
    end else if (cmd.del && (idx >= pos)) begin
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

[design/positional_array_list_core.sv]
// ----------------------------------------------------------------------------
// positional_array_list_core
// Ordered list of signed 32-bit words kept in a row of shifting cells.
// A word taken on start is captured into registers; busy then rises for one
// cycle, in which the cell row shifts and the result is captured, and no new
// word is taken; the result is then shown on out_strobe.
// Reset (rst_n low, synchronous): count cleared, capacity back to 64, no
// result pending. Cell contents are not cleared. The receiver cannot stall:
// out_strobe is high for exactly one cycle per word.
// ----------------------------------------------------------------------------
module positional_array_list_core
  import pal_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  // command channel
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_kind,
  input  logic [POS_W-1:0]  in_position,
  input  logic [WORD_W-1:0] in_value,
  // result channel
  output logic              out_strobe,
  output logic [STAT_W-1:0] out_status,
  output logic [WORD_W-1:0] out_read_value,
  output logic [POS_W-1:0]  out_count,
  // configuration
  input  logic              cfg_we,
  input  logic [CAP_W-1:0]  cfg_wdata
);

  // Count needs to hold DEPTH itself; compares run at the wider of count
  // and position widths so no bits of either are lost.
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Control state
  logic             busy_r;
  logic             strobe_r;
  logic [CNT_W-1:0] held_r;
  logic [CNT_W-1:0] held_nxt;
  logic [CAP_W-1:0] cap_r;

  // Captured command word
  logic [1:0]        kind_r;
  logic [CMP_W-1:0]  pos_r;
  logic [WORD_W-1:0] value_r;

  // Result registers
  logic [STAT_W-1:0] status_r;
  logic [STAT_W-1:0] status_nxt;
  logic [WORD_W-1:0] rdval_r;
  logic [WORD_W-1:0] rdval_nxt;
  logic [POS_W-1:0]  count_r;

  logic              accept;
  logic [CMP_W-1:0]  held_cmp;
  logic [CMP_W-1:0]  limit;
  logic              do_ins;
  logic              do_del;
  pal_cmd_t          cmd;
  logic [WORD_W-1:0] rd_bus;

  logic [WORD_W-1:0] cell_data  [DEPTH];
  logic [WORD_W-1:0] left_bus   [DEPTH];
  logic [WORD_W-1:0] right_bus  [DEPTH];

  assign accept   = start & ~busy_r;
  assign held_cmp = CMP_W'(held_r);

  // Capacity above the built depth clamps to the depth.
  assign limit = (CMP_W'(cap_r) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap_r);

  // Decode the captured word against the current count. Full is checked
  // before position for inserts; empty before position for delete and read.
  always_comb begin
    status_nxt = ST_DONE;
    rdval_nxt  = '0;
    do_ins     = 1'b0;
    do_del     = 1'b0;
    held_nxt   = held_r;
    unique case (pal_kind_t'(kind_r))
      KIND_INS: begin
        if (held_cmp >= limit) begin
          status_nxt = ST_FULL;
        end else if (pos_r > held_cmp) begin
          status_nxt = ST_RANGE;
        end else begin
          do_ins   = 1'b1;
          held_nxt = held_r + CNT_W'(1);
        end
      end
      KIND_DEL, KIND_RD: begin
        if (held_r == '0) begin
          status_nxt = ST_EMPTY;
        end else if (pos_r >= held_cmp) begin
          status_nxt = ST_RANGE;
        end else begin
          rdval_nxt = rd_bus;
          if (kind_r == KIND_DEL) begin
            do_del   = 1'b1;
            held_nxt = held_r - CNT_W'(1);
          end
        end
      end
      KIND_NOP: begin
        status_nxt = ST_DONE;
      end
      default: begin
        status_nxt = ST_DONE;
      end
    endcase
  end

  // Shifts only happen in the busy cycle; otherwise every cell holds.
  assign cmd.ins  = busy_r & do_ins;
  assign cmd.del  = busy_r & do_del;
  assign cmd.word = value_r;

  // Neighbor wiring: cell 0 never shifts in from the left, and the last cell
  // refills with its own word on delete (it is past the count afterwards).
  assign left_bus[0]        = value_r;
  assign right_bus[DEPTH-1] = cell_data[DEPTH-1];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g > 0) begin : g_left
      assign left_bus[g] = cell_data[g-1];
    end
    if (g < DEPTH - 1) begin : g_right
      assign right_bus[g] = cell_data[g+1];
    end

    pal_cell #(
      .IW (CMP_W)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .pos        (pos_r),
      .idx        (CMP_W'(g)),
      .left_data  (left_bus[g]),
      .right_data (right_bus[g]),
      .data       (cell_data[g])
    );
  end

  // Read port: each cell gates its word onto a shared OR bus when its index
  // matches the position. Sampled before the shift, so a delete returns the
  // word it removes.
  always_comb begin
    rd_bus = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (pos_r == CMP_W'(i)) begin
        rd_bus = rd_bus | cell_data[i];
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      strobe_r <= 1'b0;
      held_r   <= '0;
      cap_r    <= CAP_RESET;
    end else begin
      busy_r   <= accept;
      strobe_r <= busy_r;
      if (busy_r) begin
        held_r <= held_nxt;
      end
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  // Payload registers: capture on accept, result on the busy cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r  <= in_kind;
      pos_r   <= CMP_W'(in_position);
      value_r <= in_value;
    end
    if (busy_r) begin
      status_r <= status_nxt;
      rdval_r  <= rdval_nxt;
      count_r  <= POS_W'(held_nxt);
    end
  end

  assign busy           = busy_r;
  assign out_strobe     = strobe_r;
  assign out_status     = status_r;
  assign out_read_value = rdval_r;
  assign out_count      = count_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // A result follows its work cycle exactly.
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |=> strobe_r)
    else $error("result strobe missing after work cycle");

  // Count never exceeds the built depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_cmp <= CMP_W'(DEPTH))
    else $error("held count above depth");

  // A rejected word leaves the count untouched.
  a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && (status_nxt != ST_DONE)) |=> (held_r == $past(held_r)))
    else $error("count changed on a rejected word");

  // Only one shift direction at a time, and only in the work cycle.
  a_one_shift: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.ins || cmd.del) |-> (busy_r && !(cmd.ins && cmd.del)))
    else $error("illegal shift command");

endmodule

[dv/tb_positional_array_list_core.sv]
// ----------------------------------------------------------------------------
// tb_positional_array_list_core
// Self-checking bench for the positional array list. A tracker class keeps
// its own copy of the list and the capacity, works out the result of every
// accepted command word and compares each strobed result against it. The run
// starts with directed words, then goes through randomized phases with
// different capacities and sender idle rates.
// ----------------------------------------------------------------------------
module tb_positional_array_list_core;
  timeunit 1ns;
  timeprecision 1ps;

  import pal_pkg::*;

  localparam int DEPTH     = 64;
  localparam int CYC_LIMIT = 100000;

  typedef struct {
    pal_status_t       status;
    logic [WORD_W-1:0] read_value;
    logic [POS_W-1:0]  count;
  } list_result_t;

  // Tracks list contents and capacity; queues one expected result per word.
  class list_tracker;
    logic [WORD_W-1:0] cells [DEPTH];
    int                held;
    int                capacity;
    int                errors;
    list_result_t      pending_results [$];

    function new();
      held     = 0;
      capacity = CAP_RESET;
      errors   = 0;
      foreach (cells[i]) cells[i] = '0;
    endfunction

    function void note_word(pal_kind_t kind, logic [POS_W-1:0] pos,
                            logic [WORD_W-1:0] word);
      list_result_t r;
      int           limit;
      int           p;
      int           i;
      r.status     = ST_DONE;
      r.read_value = '0;
      p            = pos;
      limit        = (capacity > DEPTH) ? DEPTH : capacity;
      case (kind)
        KIND_INS: begin
          // full is checked before the position
          if (held >= limit) begin
            r.status = ST_FULL;
          end else if (p > held) begin
            r.status = ST_RANGE;
          end else begin
            for (i = held; i > p; i--) cells[i] = cells[i-1];
            cells[p] = word;
            held++;
          end
        end
        KIND_DEL, KIND_RD: begin
          if (held == 0) begin
            r.status = ST_EMPTY;
          end else if (p >= held) begin
            r.status = ST_RANGE;
          end else begin
            r.read_value = cells[p];
            if (kind == KIND_DEL) begin
              for (i = p; i + 1 < held; i++) cells[i] = cells[i+1];
              held--;
            end
          end
        end
        default: ;
      endcase
      r.count = POS_W'(held);
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [STAT_W-1:0] st, logic [WORD_W-1:0] rd,
                               logic [POS_W-1:0] cnt);
      list_result_t e;
      if (pending_results.size() == 0) begin
        $error("result word with nothing pending: status %0d count %0d", st, cnt);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st);
        errors++;
      end
      if (rd !== e.read_value) begin
        $error("read_value: expected %0d, got %0d",
               $signed(e.read_value), $signed(rd));
        errors++;
      end
      if (cnt !== e.count) begin
        $error("count: expected %0d, got %0d", e.count, cnt);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [1:0]        in_kind;
  logic [POS_W-1:0]  in_position;
  logic [WORD_W-1:0] in_value;
  logic              out_strobe;
  logic [STAT_W-1:0] out_status;
  logic [WORD_W-1:0] out_read_value;
  logic [POS_W-1:0]  out_count;
  logic              cfg_we;
  logic [CAP_W-1:0]  cfg_wdata;

  list_tracker tracker;
  int          idle_pct;
  int          cycles;

  positional_array_list_core #(
    .DEPTH (DEPTH)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_kind        (in_kind),
    .in_position    (in_position),
    .in_value       (in_value),
    .out_strobe     (out_strobe),
    .out_status     (out_status),
    .out_read_value (out_read_value),
    .out_count      (out_count),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Bound the run; a hang anywhere lands here.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYC_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Sample results at the rising edge; the receiver never stalls, so every
  // strobe is a result word taken.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_strobe === 1'b1)
      tracker.check_result(out_status, out_read_value, out_count);
  end

  // Drive one command word. Call at a falling edge; returns at the falling
  // edge after acceptance with start still high.
  task automatic send_word(pal_kind_t kind, logic [POS_W-1:0] pos,
                           logic [WORD_W-1:0] word);
    while ($urandom_range(99) < idle_pct) begin
      start       <= 1'b0;
      in_kind     <= 2'($urandom);
      in_position <= POS_W'($urandom);
      in_value    <= $urandom;
      @(negedge clk);
    end
    start       <= 1'b1;
    in_kind     <= kind;
    in_position <= pos;
    in_value    <= word;
    // hold the word until a rising edge sees busy low
    do @(posedge clk); while (busy !== 1'b0);
    tracker.note_word(kind, pos, word);
    @(negedge clk);
  endtask

  // Drop start and wait until every expected result has come back, then let
  // the pipeline settle.
  task automatic drain_results();
    start <= 1'b0;
    @(negedge clk);
    while (tracker.pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write the capacity register; only called with the list idle.
  task automatic write_capacity(logic [CAP_W-1:0] cap);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_wdata <= CAP_W'($urandom);
    tracker.capacity = cap;
  endtask

  function automatic logic [WORD_W-1:0] pick_value();
    case ($urandom_range(19))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Random words: mostly in-range positions so the list fills and drains,
  // with some positions anywhere in the field and a few no-op words.
  task automatic run_random(int n, int ins_pct);
    pal_kind_t        kind;
    logic [POS_W-1:0] pos;
    int               r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 3)                kind = KIND_NOP;
      else if (r < 3 + ins_pct) kind = KIND_INS;
      else if ($urandom_range(1)) kind = KIND_DEL;
      else                      kind = KIND_RD;
      if ($urandom_range(9) < 8) begin
        if (kind == KIND_INS)   pos = POS_W'($urandom_range(tracker.held));
        else if (tracker.held > 0) pos = POS_W'($urandom_range(tracker.held - 1));
        else                    pos = '0;
      end else begin
        pos = POS_W'($urandom_range(127));
      end
      send_word(kind, pos, pick_value());
      // now and then hold off until the list has answered everything
      if ($urandom_range(99) < 2) drain_results();
    end
  endtask

  initial begin
    tracker     = new();
    clk         = 1'b0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_kind     = KIND_NOP;
    in_position = '0;
    in_value    = '0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    cycles      = 0;
    idle_pct    = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty list, begin/middle/end inserts, extreme words and
    // positions, out-of-range on every kind, the no-op kind.
    send_word(KIND_RD,  7'd0,   32'h0);
    send_word(KIND_DEL, 7'd0,   32'h0);
    send_word(KIND_INS, 7'd1,   32'h1);
    send_word(KIND_INS, 7'd0,   32'h8000_0000);
    send_word(KIND_INS, 7'd1,   32'h7fff_ffff);
    send_word(KIND_INS, 7'd0,   32'hffff_ffff);
    send_word(KIND_INS, 7'd1,   32'h1234_5678);
    send_word(KIND_RD,  7'd0,   32'h0);
    send_word(KIND_RD,  7'd1,   32'h0);
    send_word(KIND_RD,  7'd2,   32'h0);
    send_word(KIND_RD,  7'd3,   32'hffff_ffff);
    send_word(KIND_RD,  7'd4,   32'h0);
    send_word(KIND_RD,  7'd127, 32'h0);
    send_word(KIND_DEL, 7'd127, 32'h0);
    send_word(KIND_INS, 7'd127, 32'hffff_ffff);
    send_word(KIND_INS, 7'd5,   32'h0);
    send_word(KIND_NOP, 7'd127, 32'hffff_ffff);
    send_word(KIND_DEL, 7'd1,   32'h0);
    send_word(KIND_DEL, 7'd0,   32'h0);
    send_word(KIND_DEL, 7'd1,   32'h0);
    send_word(KIND_RD,  7'd0,   32'h0);
    send_word(KIND_DEL, 7'd0,   32'h0);
    send_word(KIND_RD,  7'd0,   32'h0);

    // Capacity above the built depth: fill to the depth and hit full.
    write_capacity(7'd127);
    idle_pct = 0;
    run_random(150, 70);

    // Capacity below the count: entries kept, inserts full until drained.
    write_capacity(7'd5);
    idle_pct = 54;
    run_random(100, 30);

    // Capacity zero: every insert rejected.
    write_capacity(7'd0);
    idle_pct = 36;
    run_random(60, 50);

    write_capacity(7'd1);
    idle_pct = 54;
    run_random(60, 55);

    write_capacity(7'd64);
    idle_pct = 0;
    run_random(150, 60);

    write_capacity(CAP_W'($urandom_range(1, 127)));
    idle_pct = 36;
    run_random(180, 50);

    drain_results();
    repeat (4) @(negedge clk);
    if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[sim.f]
design/pal_pkg.sv
design/pal_cell.sv
design/positional_array_list_core.sv
dv/tb_positional_array_list_core.sv
